// ----- rtl/core/i2cmts_pkg.sv -----
package i2cmts_pkg;

    // Operation codes of an input item
    localparam logic [1:0] OP_LOAD_DESC = 2'd0;
    localparam logic [1:0] OP_LOAD_BYTE = 2'd1;
    localparam logic [1:0] OP_START     = 2'd2;
    localparam logic [1:0] OP_INTR      = 2'd3;

    // Controller commands
    localparam logic [2:0] CMD_NONE        = 3'd0;
    localparam logic [2:0] CMD_START_W     = 3'd1;
    localparam logic [2:0] CMD_START_R     = 3'd2;
    localparam logic [2:0] CMD_SEND        = 3'd3;
    localparam logic [2:0] CMD_RESUME_ACK  = 3'd4;
    localparam logic [2:0] CMD_RESUME_NACK = 3'd5;
    localparam logic [2:0] CMD_STOP_W      = 3'd6;
    localparam logic [2:0] CMD_STOP_R      = 3'd7;

    // Transfer status
    localparam logic [1:0] ST_IDLE      = 2'd0;
    localparam logic [1:0] ST_BUSY      = 2'd1;
    localparam logic [1:0] ST_DONE_OK   = 2'd2;
    localparam logic [1:0] ST_DONE_NDEV = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] msg_index;
        logic [6:0] slave_addr;
        logic       read_flag;
        logic [6:0] msg_length;
        logic [5:0] byte_index;
        logic [7:0] byte_value;
        logic [2:0] msg_count;
        logic       no_ack;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] command_byte;
        logic [1:0] status;
        logic       rx_valid;
        logic [1:0] rx_msg;
        logic [5:0] rx_index;
        logic [7:0] rx_data;
    } t_out_item;

endpackage

// ----- rtl/core/i2cmts_store.sv -----
module i2cmts_store
    import i2cmts_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, new data forwarded on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/i2cmts_core.sv -----
module i2cmts_core
    import i2cmts_pkg::*;
#(
    parameter int MAX_MSGS = 4,
    parameter int MAX_LEN  = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    localparam int MSG_W = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;
    localparam int TOT_W = $clog2(MAX_MSGS + 1);
    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam int DEPTH = MAX_MSGS * MAX_LEN;
    localparam int SA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_START     = 6'b000010,
        PH_READ      = 6'b000100,
        PH_WRITE     = 6'b001000,
        PH_DONE_OK   = 6'b010000,
        PH_DONE_NDEV = 6'b100000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [TOT_W-1:0]   r_total, n_total;
    logic [MSG_W-1:0]   r_cur,   n_cur;
    logic [POS_W-1:0]   r_pos,   n_pos;

    // Descriptor of the message in flight
    logic               r_c_dir,  n_c_dir;
    logic [POS_W-1:0]   r_c_len,  n_c_len;

    logic [6:0]         r_addr_tab [MAX_MSGS];
    logic               r_dir_tab  [MAX_MSGS];
    logic [POS_W-1:0]   r_len_tab  [MAX_MSGS];

    logic               busy;
    logic               last;
    logic               slot_ok;
    logic               desc_we;
    logic [MSG_W-1:0]   nx_idx;
    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   rd_pos;
    logic               wr_more;
    logic               rd_more;
    logic               rd_last;
    logic [POS_W-1:0]   len_sat;
    logic [TOT_W-1:0]   cnt_sat;
    logic [POS_W-1:0]   rd_off;
    logic               st_we;
    logic [SA_W-1:0]    st_waddr;
    logic [SA_W-1:0]    st_raddr;
    logic [7:0]         st_rdata;
    logic               step_nof;
    logic               step_stop;
    logic               stop_ok;
    t_out_item          res;

    assign busy    = (r_phase == PH_START) || (r_phase == PH_READ) || (r_phase == PH_WRITE);
    assign last    = (32'(r_cur) + 32'd1) >= 32'(r_total);
    assign nx_idx  = last ? '0 : MSG_W'(32'(r_cur) + 32'd1);
    assign pos_inc = r_pos + POS_W'(1);
    assign rd_pos  = (r_phase == PH_READ) ? pos_inc : r_pos;
    assign wr_more = r_pos < r_c_len;
    assign rd_more = rd_pos < r_c_len;
    assign rd_last = ({1'b0, rd_pos} + (POS_W + 1)'(1)) == {1'b0, r_c_len};
    assign len_sat = (32'(i_item.msg_length) > MAX_LEN) ? POS_W'(MAX_LEN)
                                                         : POS_W'(i_item.msg_length);
    assign cnt_sat = (32'(i_item.msg_count) > MAX_MSGS) ? TOT_W'(MAX_MSGS)
                                                         : TOT_W'(i_item.msg_count);
    assign slot_ok = 32'(i_item.msg_index) < MAX_MSGS;
    assign desc_we = i_fire && (i_item.op == OP_LOAD_DESC) && !busy && slot_ok;

    // Store access: write a loaded byte, prefetch the byte at the next position
    assign st_we    = i_fire && (i_item.op == OP_LOAD_BYTE) && !busy && slot_ok
                      && (32'(i_item.byte_index) < MAX_LEN);
    assign st_waddr = SA_W'(32'(i_item.msg_index) * MAX_LEN + 32'(i_item.byte_index));
    assign rd_off   = (32'(n_pos) < MAX_LEN) ? n_pos : '0;
    assign st_raddr = SA_W'(32'(n_cur) * MAX_LEN + 32'(rd_off));

    i2cmts_store #(
        .DEPTH (DEPTH),
        .AW    (SA_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (i_item.byte_value),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // Decide the command for one item
    always_comb begin
        n_phase   = r_phase;
        n_total   = r_total;
        n_cur     = r_cur;
        n_pos     = r_pos;
        n_c_dir   = r_c_dir;
        n_c_len   = r_c_len;
        res       = '0;
        step_nof  = 1'b0;
        step_stop = 1'b0;
        stop_ok   = 1'b0;
        if (i_fire) begin
            case (i_item.op)
                OP_START: begin
                    if (!busy && (i_item.msg_count != '0)) begin
                        n_total          = cnt_sat;
                        n_cur            = '0;
                        n_pos            = '0;
                        n_c_dir          = r_dir_tab[0];
                        n_c_len          = r_len_tab[0];
                        n_phase          = PH_START;
                        res.command      = r_dir_tab[0] ? CMD_START_R : CMD_START_W;
                        res.command_byte = {r_addr_tab[0], r_dir_tab[0]};
                    end
                end
                OP_INTR: begin
                    if (busy) begin
                        case (r_phase)
                            PH_START: begin
                                if (i_item.no_ack) begin
                                    step_stop = 1'b1;
                                end else if (last && !wr_more) begin
                                    step_stop = 1'b1;
                                    stop_ok   = 1'b1;
                                end else if (r_c_dir) begin
                                    n_phase = PH_READ;
                                    if (rd_more) begin
                                        res.command = rd_last ? CMD_RESUME_NACK
                                                              : CMD_RESUME_ACK;
                                    end else begin
                                        step_nof = 1'b1;
                                    end
                                end else begin
                                    n_phase = PH_WRITE;
                                    if (wr_more) begin
                                        res.command      = CMD_SEND;
                                        res.command_byte = st_rdata;
                                        n_pos            = pos_inc;
                                    end else begin
                                        step_nof = 1'b1;
                                    end
                                end
                            end
                            PH_WRITE: begin
                                if (i_item.no_ack) begin
                                    step_stop = 1'b1;
                                end else if (wr_more) begin
                                    res.command      = CMD_SEND;
                                    res.command_byte = st_rdata;
                                    n_pos            = pos_inc;
                                end else begin
                                    step_nof = 1'b1;
                                end
                            end
                            PH_READ: begin
                                res.rx_valid = 1'b1;
                                res.rx_msg   = 2'(r_cur);
                                res.rx_index = 6'(r_pos);
                                res.rx_data  = i_item.rx_byte;
                                n_pos        = pos_inc;
                                if (rd_more) begin
                                    res.command = rd_last ? CMD_RESUME_NACK
                                                          : CMD_RESUME_ACK;
                                end else begin
                                    step_nof = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase

            // Advance to the next message or finish
            if (step_nof) begin
                if (!last) begin
                    n_cur            = nx_idx;
                    n_pos            = '0;
                    n_c_dir          = r_dir_tab[nx_idx];
                    n_c_len          = r_len_tab[nx_idx];
                    n_phase          = PH_START;
                    res.command      = r_dir_tab[nx_idx] ? CMD_START_R : CMD_START_W;
                    res.command_byte = {r_addr_tab[nx_idx], r_dir_tab[nx_idx]};
                end else begin
                    step_stop = 1'b1;
                    stop_ok   = 1'b1;
                end
            end

            // Stop the bus in the direction of the current message
            if (step_stop) begin
                n_phase          = stop_ok ? PH_DONE_OK : PH_DONE_NDEV;
                res.command      = r_c_dir ? CMD_STOP_R : CMD_STOP_W;
                res.command_byte = '0;
            end
        end

        case (n_phase)
            PH_START, PH_READ, PH_WRITE: res.status = ST_BUSY;
            PH_DONE_OK:                  res.status = ST_DONE_OK;
            PH_DONE_NDEV:                res.status = ST_DONE_NDEV;
            default:                     res.status = ST_IDLE;
        endcase
    end

    assign o_result = res;

    // Transfer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_total <= '0;
            r_cur   <= '0;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_total <= n_total;
            r_cur   <= n_cur;
            r_pos   <= n_pos;
        end
    end

    // Current descriptor copy
    always_ff @(posedge i_clk) begin
        r_c_dir  <= n_c_dir;
        r_c_len  <= n_c_len;
    end

    // Descriptor tables
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_MSGS; k++) begin
            if (desc_we && (32'(i_item.msg_index) == k)) begin
                r_addr_tab[k] <= i_item.slave_addr;
                r_dir_tab[k]  <= i_item.read_flag;
                r_len_tab[k]  <= len_sat;
            end
        end
    end

endmodule

// ----- rtl/core/i2c_master_transfer_sequencer.sv -----
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   i_in_item   (t_in_item)
// out      output     o_out_valid / i_out_stall o_out_item  (t_out_item)
//
// One item per cycle while the output does not stall; each taken item goes into
// the input register, then its result into the result register, and leaves from there.
// The write byte store is read ahead, through its registered read port, at the
// position the next step needs, so the path holds.
// Reset clears the transfer state and both valid flags; descriptor and byte
// storage hold nothing defined until loaded. A stalled result holds the
// result register, and the input side stalls only when a new item waits behind it.
module i2c_master_transfer_sequencer
    import i2cmts_pkg::*;
#(
    parameter int MAX_MSGS = 4,
    parameter int MAX_LEN  = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_in_vld;
    t_in_item  r_in_item;
    logic      r_out_vld;
    t_out_item r_out_item;
    logic      advance;
    logic      accept_in;
    t_out_item core_res;

    // Move the held item into the result register when it is free
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign accept_in  = i_in_valid && !o_in_stall;

    i2cmts_core #(
        .MAX_MSGS (MAX_MSGS),
        .MAX_LEN  (MAX_LEN)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .o_result (core_res)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept_in) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= core_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule
